/* sv/edn_pkg.sv */
// Shared types, widths and register codes for the encoder delta normalizer.
package edn_pkg;

  localparam int unsigned ScaleW   = 13;
  localparam int unsigned IntvW    = 8;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CountW   = 32;
  localparam int unsigned DeltaW   = 8;
  localparam int unsigned FracBits = 8;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned DataW    = 32;

  localparam logic signed [CountW-1:0] EdgeLow  = 32'sd1;
  localparam logic signed [CountW-1:0] EdgeHigh = 32'sd126;

  localparam logic [ScaleW-1:0] ScaleRst   = 13'd256;
  localparam logic [IntvW-1:0]  MinIntvRst = 8'd1;
  localparam logic [IntvW-1:0]  EdgeIntvRst = 8'd4;

  localparam logic [1:0] RegScale    = 2'd0;
  localparam logic [1:0] RegMinIntv  = 2'd1;
  localparam logic [1:0] RegEdgeIntv = 2'd2;

  typedef struct packed {
    logic [ScaleW-1:0] scale;
    logic [IntvW-1:0]  min_intv;
    logic [IntvW-1:0]  edge_intv;
  } edn_cfg_t;

  typedef struct packed {
    logic              cmd;
    logic              chg;
    logic [CountW-1:0] delta;
    logic [CountW-1:0] pos;
  } edn_stage_t;

endpackage

/* sv/encoder_delta_normalizer.sv */
// Top level of the encoder delta normalizer: rate filter, position tracking, scaling.
// Usage:
//   Input words (command_i, time_ms_i, encoder_count_i) arrive on a valid/ready
//   channel; each word yields exactly one output word (scaled_delta_o,
//   physical_position_o, absolute_position_o) on a second valid/ready channel.
//   Configuration goes through an APB port: scale factor at 0x0, minimum
//   interval at 0x4, edge interval at 0x8; pready is always high.
//   Stage one registers the filter decision and updates count, position and
//   timers; stage two forms the two scale products and holds the output word.
//   An accepted word is registered in stage one and then in stage two, which
//   holds the output word; one word is accepted per cycle while the receiver
//   does not stall, as the filter and position update in stage one are combinational.
//   Reset clears positions, timers and the last count, loads the register
//   defaults and empties both stages.
//   When the receiver stalls, the output word holds, stage one fills, and then
//   in_ready_o drops until the output word is taken.
module encoder_delta_normalizer
  import edn_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [AddrW-1:0]         paddr,
  input  logic [DataW-1:0]         pwdata,
  output logic [DataW-1:0]         prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     command_i,
  input  logic [TimeW-1:0]         time_ms_i,
  input  logic signed [CountW-1:0] encoder_count_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DeltaW-1:0] scaled_delta_o,
  output logic signed [CountW-1:0] physical_position_o,
  output logic signed [CountW-1:0] absolute_position_o
);

  edn_cfg_t cfg;

  edn_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic [CountW-1:0] last_count_q;
  logic [CountW-1:0] pos_q;
  logic [TimeW-1:0]  last_time_q;
  logic [TimeW-1:0]  edge_time_q;

  logic              s1_valid_q;
  edn_stage_t        s1_q;
  edn_stage_t        s1_d;
  logic              s2_ready;
  logic              in_fire;
  logic              s1_fire;

  logic              out_valid_q;
  logic [DeltaW-1:0] delta_q;
  logic [CountW-1:0] phys_q;
  logic [CountW-1:0] abs_q;

  logic [TimeW-1:0]  dt_last;
  logic [TimeW-1:0]  dt_edge;
  logic [CountW-1:0] delta;
  logic [CountW-1:0] pos_new;
  logic              too_soon;
  logic              at_edge;
  logic              edge_soon;
  logic              chg;

  logic [DeltaW-1:0] norm;
  logic [CountW-1:0] abs_next;

  assign s2_ready   = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s2_ready;
  assign in_fire    = in_valid_i && in_ready_o;
  assign s1_fire    = s1_valid_q && s2_ready;

  assign dt_last  = time_ms_i - last_time_q;
  assign dt_edge  = time_ms_i - edge_time_q;
  assign delta    = encoder_count_i - last_count_q;
  assign pos_new  = pos_q + delta;
  assign too_soon = dt_last < {{(TimeW-IntvW){1'b0}}, cfg.min_intv};
  assign at_edge  = ($signed(pos_q) <= EdgeLow && delta[CountW-1])
                 || ($signed(pos_q) >= EdgeHigh && !delta[CountW-1] && delta != '0);
  assign edge_soon = at_edge && (dt_edge < {{(TimeW-IntvW){1'b0}}, cfg.edge_intv});
  assign chg      = !command_i && !too_soon && (delta != '0) && !edge_soon;

  always_comb begin
    s1_d.cmd   = command_i;
    s1_d.chg   = chg;
    s1_d.delta = delta;
    if (command_i) begin
      s1_d.pos = '0;
    end else if (chg) begin
      s1_d.pos = pos_new;
    end else begin
      s1_d.pos = pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_count_q <= '0;
      pos_q        <= '0;
      last_time_q  <= '0;
      edge_time_q  <= '0;
    end else if (in_fire) begin
      pos_q <= s1_d.pos;
      if (chg) begin
        last_count_q <= encoder_count_i;
        last_time_q  <= time_ms_i;
        if (at_edge) begin
          edge_time_q <= time_ms_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
  end

  edn_scale u_scale (
    .delta_i (s1_q.delta),
    .pos_i   (s1_q.pos),
    .scale_i (cfg.scale),
    .norm_o  (norm),
    .abs_o   (abs_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      abs_q       <= '0;
    end else begin
      if (s2_ready) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_fire) begin
        if (s1_q.cmd) begin
          abs_q <= '0;
        end else if (s1_q.chg) begin
          abs_q <= abs_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      delta_q <= s1_q.chg ? norm : '0;
      phys_q  <= s1_q.pos;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign scaled_delta_o      = $signed(delta_q);
  assign physical_position_o = $signed(phys_q);
  assign absolute_position_o = $signed(abs_q);

  a_cmd_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_q.cmd |=> out_valid_o && scaled_delta_o == '0
      && physical_position_o == '0 && absolute_position_o == '0)
    else $error("reset command did not clear the output word");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_ready |=> s1_valid_q && $stable(s1_q))
    else $error("stage one word lost under stall");

  a_no_move_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !chg |=> $stable(last_count_q) && $stable(last_time_q)
      && $stable(edge_time_q))
    else $error("filtered word changed tracking state");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && !s1_q.chg |=> scaled_delta_o == '0)
    else $error("filtered word produced a nonzero delta");

endmodule

/* sv/edn_cfg.sv */
// APB configuration registers of the encoder delta normalizer.
module edn_cfg
  import edn_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output edn_cfg_t         cfg_o
);

  edn_cfg_t cfg_q;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale     <= ScaleRst;
      cfg_q.min_intv  <= MinIntvRst;
      cfg_q.edge_intv <= EdgeIntvRst;
    end else if (wr_en) begin
      case (paddr[3:2])
        RegScale:    cfg_q.scale     <= pwdata[ScaleW-1:0];
        RegMinIntv:  cfg_q.min_intv  <= pwdata[IntvW-1:0];
        RegEdgeIntv: cfg_q.edge_intv <= pwdata[IntvW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegScale:    prdata = {{(DataW-ScaleW){1'b0}}, cfg_q.scale};
      RegMinIntv:  prdata = {{(DataW-IntvW){1'b0}}, cfg_q.min_intv};
      RegEdgeIntv: prdata = {{(DataW-IntvW){1'b0}}, cfg_q.edge_intv};
      default:     prdata = '0;
    endcase
  end

endmodule

/* sv/edn_scale.sv */
// Delta scaling with saturation and a magnitude of at least one, and absolute position scaling.
module edn_scale
  import edn_pkg::*;
(
  input  logic [CountW-1:0] delta_i,
  input  logic [CountW-1:0] pos_i,
  input  logic [ScaleW-1:0] scale_i,
  output logic [DeltaW-1:0] norm_o,
  output logic [CountW-1:0] abs_o
);

  localparam int unsigned ProdW = CountW + ScaleW + 1;

  logic signed [ProdW-1:0]  prod;
  logic signed [ProdW-1:0]  shifted;
  logic [CountW-1:0]        plow;

  assign prod    = $signed(delta_i) * $signed({1'b0, scale_i});
  assign shifted = prod >>> FracBits;

  always_comb begin
    if (shifted == '0) begin
      norm_o = delta_i[CountW-1] ? '1 : DeltaW'(1);
    end else if (shifted > ProdW'(127)) begin
      norm_o = 8'sd127;
    end else if (shifted < -ProdW'(128)) begin
      norm_o = 8'h80;
    end else begin
      norm_o = shifted[DeltaW-1:0];
    end
  end

  assign plow  = pos_i * {{(CountW-ScaleW){1'b0}}, scale_i};
  assign abs_o = CountW'($signed(plow) >>> FracBits);

endmodule

/* sim/encoder_delta_normalizer_tb.sv */
// Self-checking testbench for encoder_delta_normalizer: rate filter, positions and scaling.
module encoder_delta_normalizer_tb
  import edn_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned IdlePct    = 12;
  localparam int unsigned HoldCycles = 150;

  typedef struct packed {
    logic                     cmd;
    logic [TimeW-1:0]         t;
    logic signed [CountW-1:0] cnt;
  } sample_t;

  typedef struct packed {
    logic signed [DeltaW-1:0] delta;
    logic signed [CountW-1:0] phys;
    logic signed [CountW-1:0] absp;
  } motion_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [AddrW-1:0]         paddr = '0;
  logic [DataW-1:0]         pwdata = '0;
  logic [DataW-1:0]         prdata;
  logic                     pready;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic                     command_i = 1'b0;
  logic [TimeW-1:0]         time_ms_i = '0;
  logic signed [CountW-1:0] encoder_count_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [DeltaW-1:0] scaled_delta_o;
  logic signed [CountW-1:0] physical_position_o;
  logic signed [CountW-1:0] absolute_position_o;

  logic calm = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;
  int unsigned errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_seen = 0;
  int unsigned n_moves = 0;
  int unsigned n_quiet = 0;
  int unsigned n_clears = 0;

  sample_t pending[$];
  motion_t motion_due[$];

  logic [ScaleW-1:0]        scale_cfg = ScaleRst;
  logic [IntvW-1:0]         min_gap_cfg = MinIntvRst;
  logic [IntvW-1:0]         edge_gap_cfg = EdgeIntvRst;
  logic signed [CountW-1:0] last_cnt = '0;
  logic signed [CountW-1:0] pos_acc = '0;
  logic signed [CountW-1:0] abs_pos = '0;
  logic [TimeW-1:0]         last_move_t = '0;
  logic [TimeW-1:0]         edge_move_t = '0;

  logic [TimeW-1:0]         stamp = '0;
  logic signed [CountW-1:0] tick = '0;

  encoder_delta_normalizer uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .command_i           (command_i),
    .time_ms_i           (time_ms_i),
    .encoder_count_i     (encoder_count_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .scaled_delta_o      (scaled_delta_o),
    .physical_position_o (physical_position_o),
    .absolute_position_o (absolute_position_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic motion_t track_motion(input sample_t s);
    motion_t                  r;
    logic [TimeW-1:0]         since_move;
    logic [TimeW-1:0]         since_edge;
    logic signed [CountW-1:0] d;
    logic signed [CountW-1:0] pos;
    logic signed [CountW-1:0] sp;
    logic signed [63:0]       prod;
    logic                     near_end;
    r.delta = '0;
    if (s.cmd) begin
      pos_acc = '0;
      abs_pos = '0;
      n_clears++;
    end else begin
      since_move = s.t - last_move_t;
      since_edge = s.t - edge_move_t;
      d = s.cnt - last_cnt;
      pos = pos_acc;
      near_end = (pos <= EdgeLow && d < 0) || (pos >= EdgeHigh && d > 0);
      if (since_move < min_gap_cfg || d == 0 || (near_end && since_edge < edge_gap_cfg)) begin
        n_quiet++;
      end else begin
        if (near_end) edge_move_t = s.t;
        last_move_t = s.t;
        last_cnt = s.cnt;
        pos_acc = pos_acc + d;
        prod = 64'(d) * $signed({51'b0, scale_cfg});
        prod = prod >>> FracBits;
        if (prod == 0) prod = (d > 0) ? 64'sd1 : -64'sd1;
        if (prod > 127) prod = 127;
        else if (prod < -128) prod = -128;
        r.delta = prod[DeltaW-1:0];
        sp = pos_acc * $signed({19'b0, scale_cfg});
        abs_pos = sp >>> FracBits;
        n_moves++;
      end
    end
    r.phys = pos_acc;
    r.absp = abs_pos;
    return r;
  endfunction

  task automatic push_move(logic cmd, logic [TimeW-1:0] dt, logic signed [CountW-1:0] dc);
    sample_t s;
    stamp += dt;
    tick += dc;
    s.cmd = cmd;
    s.t = stamp;
    s.cnt = tick;
    pending.push_back(s);
  endtask

  task automatic push_samples(int unsigned n, int bias);
    int unsigned roll;
    int          step;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        stamp = $urandom();
        tick = $urandom();
        push_move(1'b0, '0, '0);
      end else begin
        step = (roll < 18) ? int'($urandom_range(0, 512)) - 256
                           : int'($urandom_range(0, 4)) - 2 + bias;
        push_move(roll >= 96, (roll < 12) ? $urandom_range(0, 400) : $urandom_range(0, 5),
                  step);
      end
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [DataW-1:0] val);
    logic [DataW-1:0] back;
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= AddrW'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      RegScale: begin
        scale_cfg = val[ScaleW-1:0];
        back = DataW'(scale_cfg);
      end
      RegMinIntv: begin
        min_gap_cfg = val[IntvW-1:0];
        back = DataW'(min_gap_cfg);
      end
      default: begin
        edge_gap_cfg = val[IntvW-1:0];
        back = DataW'(edge_gap_cfg);
      end
    endcase
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== back) begin
      $error("prdata at 0x%0h expected 0x%0h got 0x%0h", {idx, 2'b00}, back, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_rates(logic [ScaleW-1:0] k, logic [IntvW-1:0] m, logic [IntvW-1:0] e);
    write_reg(RegScale, DataW'(k));
    write_reg(RegMinIntv, DataW'(m));
    write_reg(RegEdgeIntv, DataW'(e));
  endtask

  task automatic settle();
    while (pending.size() != 0 || in_valid_i || motion_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : drive
    logic took;
    logic gap;
    if (rst_ni) begin
      took = in_valid_i && in_ready_o;
      if (took) begin
        motion_due.push_back(track_motion(pending.pop_front()));
        n_sent++;
      end
      if (!in_valid_i || took) begin
        gap = !calm && ($urandom_range(0, 99) < IdlePct);
        if (pending.size() != 0 && !gap) begin
          command_i <= pending[0].cmd;
          time_ms_i <= pending[0].t;
          encoder_count_i <= pending[0].cnt;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watch
    motion_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        n_seen++;
        if (motion_due.size() == 0) begin
          $error("output word with nothing expected");
          errors++;
        end else begin
          want = motion_due.pop_front();
          if (scaled_delta_o !== want.delta) begin
            $error("scaled_delta expected %0d got %0d", want.delta, scaled_delta_o);
            errors++;
          end
          if (physical_position_o !== want.phys) begin
            $error("physical_position expected %0d got %0d", want.phys, physical_position_o);
            errors++;
          end
          if (absolute_position_o !== want.absp) begin
            $error("absolute_position expected %0d got %0d", want.absp, absolute_position_o);
            errors++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_left = HoldCycles;
        hold_done <= 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_move(1'b0, 0, 0);
    push_move(1'b0, 1, 0);
    push_move(1'b0, 1, 3);
    push_move(1'b0, 0, 6);
    push_move(1'b0, 1, -8);
    push_move(1'b0, 1, -1);
    push_move(1'b0, 1, -1);
    push_move(1'b0, 4, -1);
    push_move(1'b0, 20, 32'sh8000_0000);
    push_move(1'b1, 1, 0);
    push_move(1'b0, 30, 32'sh7FFF_FFFF);
    push_move(1'b0, 30, 200);
    push_move(1'b0, 1, 5);
    stamp = 32'hFFFF_FFF0;
    push_move(1'b0, 0, 1);
    push_move(1'b0, 20, 1);
    stamp = '1;
    tick = '1;
    push_move(1'b1, 0, 0);
    push_samples(200, 0);
    settle();

    set_rates(13'd1, 8'd0, 8'd0);
    calm <= 1'b1;
    push_move(1'b1, 1, 0);
    push_move(1'b0, 1, 50);
    push_move(1'b0, 1, 1);
    push_move(1'b0, 1, -1);
    push_move(1'b0, 1, -255);
    push_move(1'b0, 1, 256);
    push_move(1'b0, 0, 7);
    push_samples(200, 1);
    settle();
    calm <= 1'b0;

    set_rates(13'd0, 8'd255, 8'd255);
    push_move(1'b0, 300, 3);
    push_move(1'b0, 300, -3);
    push_samples(150, 0);
    settle();

    set_rates(13'd6144, 8'd2, 8'd8);
    push_move(1'b0, 300, 1);
    push_move(1'b0, 300, 6);
    push_move(1'b0, 300, -6);
    push_samples(250, -1);
    hold_req <= 1'b1;
    settle();

    set_rates(ScaleW'($urandom_range(0, 6144)), IntvW'($urandom_range(0, 10)),
              IntvW'($urandom_range(0, 20)));
    push_samples(250, 0);
    settle();

    set_rates(ScaleRst, MinIntvRst, EdgeIntvRst);
    push_samples(250, 1);
    settle();

    $display("%0d samples in, %0d words checked: %0d moves, %0d held or still, %0d clears",
             n_sent, n_seen, n_moves, n_quiet, n_clears);
    $display("scale 0..6144, intervals 0..255, time wrap, one %0d-cycle output stall",
             HoldCycles);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
